// ===== rtl/spa_pkg.sv =====
// Shared types and constants for the sparse polynomial arithmetic unit.
`default_nettype none
package spa_pkg;

  localparam int MAX_TERMS  = 8;
  localparam int PROD_DEPTH = MAX_TERMS * MAX_TERMS;
  localparam int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int COEF_W     = 16;
  localparam int EXP_W      = 8;
  localparam int RCOEF_W    = 35;
  localparam int REXP_W     = 9;

  localparam logic [1:0] MODE_SUB = 2'd1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COMPUTE,
    ST_EMIT
  } spa_state_t;

  // One stored input term.
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         expo;
  } in_term_t;

  // One result term held in a cell of the chain.
  typedef struct packed {
    logic                      valid;
    logic signed [RCOEF_W-1:0] coef;
    logic [REXP_W-1:0]         expo;
  } entry_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic   clear;
    logic   insert;
    logic   hit;
    logic   pop;
    entry_t ins;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/spa_cell.sv =====
// One cell of the sorted term chain: holds one result term.
`default_nettype none
module spa_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spa_pkg::cell_ctl_t ctl,
  input  wire spa_pkg::entry_t    prev_entry,
  input  wire logic               prev_gt,
  input  wire spa_pkg::entry_t    next_entry,
  output spa_pkg::entry_t         entry,
  output logic                    match,
  output logic                    gt
);
  import spa_pkg::*;

  // Compare the held term with the incoming one.
  assign match = entry.valid && (entry.expo == ctl.ins.expo);
  assign gt    = entry.valid && (entry.expo > ctl.ins.expo);

  // Accumulate, take the new word, take the neighbour's word, or move up for output.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      entry <= '0;
    end else if (ctl.pop) begin
      entry <= next_entry;
    end else if (ctl.insert) begin
      if (match) begin
        entry.coef <= entry.coef + ctl.ins.coef;
      end else if (!ctl.hit && !gt) begin
        entry <= prev_gt ? ctl.ins : prev_entry;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spa_chain.sv =====
// Row of cells that keeps result terms sorted by falling exponent.
`default_nettype none
module spa_chain (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spa_pkg::cell_ctl_t ctl_in,
  output spa_pkg::entry_t         head,
  output logic                    second_valid
);
  import spa_pkg::*;

  entry_t                entries [PROD_DEPTH];
  logic [PROD_DEPTH-1:0] eq_hits;
  logic [PROD_DEPTH-1:0] gts;
  cell_ctl_t             ctl;

  // An equal exponent anywhere stops the shift.
  always_comb begin
    ctl     = ctl_in;
    ctl.hit = |eq_hits;
  end

  genvar g;
  generate
    for (g = 0; g < PROD_DEPTH; g++) begin : g_cell
      entry_t pe;
      entry_t ne;
      logic   pg;
      if (g == 0) begin : g_first
        assign pe = ctl_in.ins;
        assign pg = 1'b1;
      end else begin : g_mid
        assign pe = entries[g-1];
        assign pg = gts[g-1];
      end
      if (g == PROD_DEPTH - 1) begin : g_end
        assign ne = '0;
      end else begin : g_inner
        assign ne = entries[g+1];
      end
      spa_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .prev_entry (pe),
        .prev_gt    (pg),
        .next_entry (ne),
        .entry      (entries[g]),
        .match      (eq_hits[g]),
        .gt         (gts[g])
      );
    end
  endgenerate

  assign head = entries[0];
  generate
    if (PROD_DEPTH > 1) begin : g_sec
      assign second_valid = entries[1].valid;
    end else begin : g_nosec
      assign second_valid = 1'b0;
    end
  endgenerate

endmodule
`default_nettype wire

// ===== rtl/sparse_polynomial_arith_unit.sv =====
// Top level of the sparse polynomial add, subtract and multiply unit.
// Terms load one word per cycle into two 8-entry term stores. The word marked
// last starts the computation: every term (add or subtract) or every pairwise
// product (multiply) is generated at one per cycle and inserted into a chain of
// 64 sorting cells, which sums equal exponents on the fly. When the generator is
// done, the result words leave the head of the chain at one per cycle while
// out_ready is high. No input word is taken while a computation or its output
// is in progress.
`default_nettype none
module sparse_polynomial_arith_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [1:0]                          cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                to_second,
  input  wire logic                                has_term,
  input  wire logic signed [spa_pkg::COEF_W-1:0]   coefficient,
  input  wire logic [spa_pkg::EXP_W-1:0]           exponent,
  input  wire logic                                last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [spa_pkg::RCOEF_W-1:0]       result_coefficient,
  output logic [spa_pkg::REXP_W-1:0]               result_exponent,
  output logic                                     last_term,
  output logic                                     empty_res
);
  import spa_pkg::*;

  spa_state_t       state, state_next;
  logic [1:0]       arith_mode;
  in_term_t         first_terms  [MAX_TERMS];
  in_term_t         second_terms [MAX_TERMS];
  logic [CNT_W-1:0] first_count, second_count;
  logic [EXP_W-1:0] first_last_exp, second_last_exp;
  logic [CNT_W-1:0] idx_a, idx_b;
  logic             sel_b;
  logic             gen_done;
  logic             gen_emit;
  entry_t           gen_term;
  entry_t           stage;
  cell_ctl_t        ctl;
  entry_t           head;
  logic             second_valid;
  logic             in_acc, out_acc;
  logic             load_first, load_second;
  logic             is_mul;
  in_term_t         ta, tb;
  logic signed [2*COEF_W-1:0] prod;

  // Mode register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      arith_mode <= '0;
    end else if (cfg_valid && cfg_ready) begin
      arith_mode <= cfg_data;
    end
  end

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign is_mul  = arith_mode[1];

  // Term acceptance: nonzero, room left and strictly falling exponent.
  assign load_first = in_acc && has_term && !to_second && (coefficient != '0) &&
                      (first_count < CNT_W'(MAX_TERMS)) &&
                      ((first_count == '0) || (exponent < first_last_exp));
  assign load_second = in_acc && has_term && to_second && (coefficient != '0) &&
                       (second_count < CNT_W'(MAX_TERMS)) &&
                       ((second_count == '0) || (exponent < second_last_exp));

  // Term stores.
  always_ff @(posedge clk) begin
    if (load_first) begin
      first_terms[first_count[IDX_W-1:0]] <= '{coef: coefficient, expo: exponent};
      first_last_exp <= exponent;
    end
    if (load_second) begin
      second_terms[second_count[IDX_W-1:0]] <= '{coef: coefficient, expo: exponent};
      second_last_exp <= exponent;
    end
  end

  // Term counts, cleared when a computation finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
    end else if (state == ST_COMPUTE && gen_done) begin
      first_count  <= '0;
      second_count <= '0;
    end else begin
      if (load_first) first_count <= first_count + 1'b1;
      if (load_second) second_count <= second_count + 1'b1;
    end
  end

  // Term generator: reads one stored term from each store per cycle.
  assign ta   = first_terms[idx_a[IDX_W-1:0]];
  assign tb   = second_terms[idx_b[IDX_W-1:0]];
  assign prod = ta.coef * tb.coef;

  always_comb begin
    gen_done = 1'b0;
    gen_emit = 1'b0;
    gen_term = '0;
    if (is_mul) begin
      if (first_count == '0 || idx_b >= second_count) begin
        gen_done = 1'b1;
      end else begin
        gen_emit      = 1'b1;
        gen_term.coef = {{(RCOEF_W-2*COEF_W){prod[2*COEF_W-1]}}, prod};
        gen_term.expo = {1'b0, ta.expo} + {1'b0, tb.expo};
      end
    end else if (!sel_b) begin
      if (idx_a < first_count) begin
        gen_emit      = 1'b1;
        gen_term.coef = {{(RCOEF_W-COEF_W){ta.coef[COEF_W-1]}}, ta.coef};
        gen_term.expo = {1'b0, ta.expo};
      end
    end else if (idx_b < second_count) begin
      gen_emit      = 1'b1;
      gen_term.coef = {{(RCOEF_W-COEF_W){tb.coef[COEF_W-1]}}, tb.coef};
      if (arith_mode == MODE_SUB) gen_term.coef = -gen_term.coef;
      gen_term.expo = {1'b0, tb.expo};
    end else begin
      gen_done = 1'b1;
    end
    gen_term.valid = gen_emit;
  end

  // Generator indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_a <= '0;
      idx_b <= '0;
      sel_b <= 1'b0;
    end else if (state != ST_COMPUTE) begin
      idx_a <= '0;
      idx_b <= '0;
      sel_b <= 1'b0;
    end else if (is_mul) begin
      if (gen_emit) begin
        if (idx_a == first_count - 1'b1) begin
          idx_a <= '0;
          idx_b <= idx_b + 1'b1;
        end else begin
          idx_a <= idx_a + 1'b1;
        end
      end
    end else if (!sel_b) begin
      if (gen_emit) idx_a <= idx_a + 1'b1;
      else sel_b <= 1'b1;
    end else if (gen_emit) begin
      idx_b <= idx_b + 1'b1;
    end
  end

  // Stage register between the multiplier and the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else if (state == ST_COMPUTE) begin
      stage <= gen_term;
    end else begin
      stage <= '0;
    end
  end

  // Chain control.
  always_comb begin
    ctl        = '0;
    ctl.clear  = in_acc && last;
    ctl.insert = stage.valid;
    ctl.pop    = out_acc;
    ctl.ins    = stage;
  end

  spa_chain u_chain (
    .clk          (clk),
    .rst          (rst),
    .ctl_in       (ctl),
    .head         (head),
    .second_valid (second_valid)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:    if (in_acc && last) state_next = ST_COMPUTE;
      ST_COMPUTE: if (gen_done) state_next = ST_EMIT;
      ST_EMIT:    if (out_acc && last_term) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready           = (state == ST_LOAD);
    out_valid          = (state == ST_EMIT);
    empty_res          = !head.valid;
    last_term          = !head.valid || !second_valid;
    result_coefficient = head.valid ? head.coef : '0;
    result_exponent    = head.valid ? head.expo : '0;
  end

endmodule
`default_nettype wire

// ===== test/sparse_polynomial_arith_unit_tb.sv =====
// Self-checking testbench for the sparse polynomial add, subtract and multiply unit.
`default_nettype none
module sparse_polynomial_arith_unit_tb;
  import spa_pkg::*;

  typedef struct packed {
    logic              to_second;
    logic              has_term;
    logic signed [15:0] coefficient;
    logic [7:0]        exponent;
    logic              last;
  } term_word_t;

  typedef struct packed {
    logic signed [RCOEF_W-1:0] coef;
    logic [REXP_W-1:0]         expo;
    logic                      last_term;
    logic                      empty_res;
  } result_word_t;

  localparam int ADD_MODE = 0;
  localparam int MUL_MODE = 2;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = 2'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic to_second = 1'b0;
  logic has_term = 1'b0;
  logic signed [COEF_W-1:0] coefficient = '0;
  logic [EXP_W-1:0] exponent = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RCOEF_W-1:0] result_coefficient;
  logic [REXP_W-1:0] result_exponent;
  logic last_term;
  logic empty_res;

  sparse_polynomial_arith_unit i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .to_second(to_second), .has_term(has_term), .coefficient(coefficient),
    .exponent(exponent), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_coefficient(result_coefficient), .result_exponent(result_exponent),
    .last_term(last_term), .empty_res(empty_res)
  );

  always #5 clk = ~clk;

  // Predictor state: the two loaded polynomials and the selected operation.
  logic [1:0] op_mode = 2'd0;
  logic signed [63:0] poly_coef [2][MAX_TERMS];
  int unsigned poly_expo [2][MAX_TERMS];
  int unsigned poly_len [2] = '{0, 0};

  term_word_t pending_words[$];
  result_word_t expected_terms[$];
  int mismatches = 0;
  int unsigned cycle_count = 0;
  bit hold_off = 1'b0;

  function automatic void push_term(logic signed [63:0] c, int unsigned e, bit fin,
                                    bit emp);
    result_word_t r;
    r.coef = c[RCOEF_W-1:0];
    r.expo = e[REXP_W-1:0];
    r.last_term = fin;
    r.empty_res = emp;
    expected_terms.push_back(r);
  endfunction

  // Works out the result words caused by one accepted word.
  function automatic void predict_polynomial(term_word_t w);
    int p;
    int n;
    int i;
    int j;
    int k;
    int q;
    logic signed [63:0] rc [$];
    int unsigned re [$];
    logic signed [63:0] c;
    int unsigned e;
    p = w.to_second;
    n = poly_len[p];
    if (w.has_term && w.coefficient != 0 && n < MAX_TERMS &&
        (n == 0 || w.exponent < poly_expo[p][n-1])) begin
      poly_coef[p][n] = 64'(w.coefficient);
      poly_expo[p][n] = 32'(w.exponent);
      poly_len[p] = n + 1;
    end
    if (!w.last) return;
    if (op_mode[1]) begin
      // Partial products sorted by falling exponent, equal exponents summed.
      for (j = 0; j < poly_len[1]; j++) begin
        for (i = 0; i < poly_len[0]; i++) begin
          c = poly_coef[0][i] * poly_coef[1][j];
          e = poly_expo[0][i] + poly_expo[1][j];
          q = 0;
          while (q < re.size() && re[q] > e) q++;
          if (q < re.size() && re[q] == e) rc[q] = rc[q] + c;
          else begin
            rc.insert(q, c);
            re.insert(q, e);
          end
        end
      end
    end else begin
      i = 0;
      j = 0;
      while (i < poly_len[0] || j < poly_len[1]) begin
        if (i < poly_len[0] && j < poly_len[1] &&
            poly_expo[0][i] == poly_expo[1][j]) begin
          rc.push_back(op_mode == MODE_SUB ? poly_coef[0][i] - poly_coef[1][j]
                                           : poly_coef[0][i] + poly_coef[1][j]);
          re.push_back(poly_expo[0][i]);
          i++;
          j++;
        end else if (j >= poly_len[1] ||
                     (i < poly_len[0] && poly_expo[0][i] > poly_expo[1][j])) begin
          rc.push_back(poly_coef[0][i]);
          re.push_back(poly_expo[0][i]);
          i++;
        end else begin
          rc.push_back(op_mode == MODE_SUB ? -poly_coef[1][j] : poly_coef[1][j]);
          re.push_back(poly_expo[1][j]);
          j++;
        end
      end
    end
    if (rc.size() == 0) push_term(0, 0, 1'b1, 1'b1);
    for (k = 0; k < rc.size(); k++) push_term(rc[k], re[k], k == rc.size() - 1, 1'b0);
    poly_len[0] = 0;
    poly_len[1] = 0;
  endfunction

  // Driver: offers queued words with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_polynomial('{to_second, has_term, coefficient, exponent, last});
        void'(pending_words.pop_front());
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        {to_second, has_term, coefficient, exponent, last} <= pending_words[0];
      end else in_valid <= 1'b0;
    end
  end

  // Monitor: random back-pressure, compares each word with the oldest expectation.
  int recv_gap = 0;
  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst) begin
      cycle_count++;
      if (out_valid && out_ready) begin
        got = '{result_coefficient, result_exponent, last_term, empty_res};
        if (expected_terms.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word: coef %0d expo %0d", got.coef, got.expo);
        end else begin
          want = expected_terms.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: expected coef %0d expo %0d last %0b empty %0b,",
                        " got coef %0d expo %0d last %0b empty %0b"},
                       want.coef, want.expo, want.last_term, want.empty_res,
                       got.coef, got.expo, got.last_term, got.empty_res);
          end
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      if (hold_off) out_ready <= 1'b0;
      else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // A long receiver stall on request, counted here in cycles.
  int unsigned stall_cycles = 0;
  always @(posedge clk) begin
    if (stall_cycles > 0) begin
      stall_cycles--;
      if (stall_cycles == 0) hold_off <= 1'b0;
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic term_word_t make_word(int sec, int ht, int c, int e, int fin);
    term_word_t w;
    w.to_second = sec[0];
    w.has_term = ht[0];
    w.coefficient = c[15:0];
    w.exponent = e[7:0];
    w.last = fin[0];
    return w;
  endfunction

  // One well-formed run with random content, plus some noise words.
  task automatic queue_random_run();
    int p;
    int n;
    int e;
    int t;
    for (p = 0; p < 2; p++) begin
      n = $urandom_range(0, 9);
      e = $urandom_range(200, 255);
      for (t = 0; t < n; t++) begin
        if ($urandom_range(0, 9) == 0)
          pending_words.push_back(make_word(p, $urandom, $urandom, $urandom, 0));
        else
          pending_words.push_back(make_word(p, 1,
            ($urandom_range(0, 9) == 0) ? 0 : $urandom, e, 0));
        e = e - $urandom_range(1, 30);
        if (e < 0) e = 0;
      end
    end
    pending_words.push_back(make_word($urandom, $urandom, $urandom, $urandom, 1));
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_terms.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    op_mode = m;
  endtask

  initial begin
    int m;
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed words: extremes, zero, out of order, overflow, bare and empty runs.
    for (m = 0; m < 4; m++) begin
      write_mode(m[1:0]);
      pending_words.push_back(make_word(0, 1, -32768, 255, 0));
      pending_words.push_back(make_word(0, 1, 0, 200, 0));
      pending_words.push_back(make_word(0, 1, 5, 255, 0));
      pending_words.push_back(make_word(0, 1, 32767, 0, 0));
      pending_words.push_back(make_word(1, 1, -32768, 255, 0));
      pending_words.push_back(make_word(1, 1, 32767, 0, 1));
      pending_words.push_back(make_word(1, 0, 0, 0, 1));
      if (m == 0) begin
        for (k = 0; k < 10; k++) pending_words.push_back(make_word(1, 1, 3, 20 - k, 0));
        pending_words.push_back(make_word(0, 1, 7, 20, 1));
      end
      wait_idle();
    end
    // Random runs in add mode, mode 3 and random modes, one of them under a long receiver stall.
    for (k = 0; k < 10; k++) begin
      write_mode((k == 0) ? 2'(ADD_MODE) : (k == 1) ? 2'd3 : 2'($urandom_range(0, 3)));
      queue_random_run();
      if (k == 4) begin
        hold_off <= 1'b1;
        stall_cycles <= 400;
        repeat (6) queue_random_run();
      end
      wait_idle();
    end
    write_mode(2'(MUL_MODE));
    queue_random_run();
    wait_idle();
    if (mismatches == 0 && expected_terms.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/spa_pkg.sv
rtl/spa_cell.sv
rtl/spa_chain.sv
rtl/sparse_polynomial_arith_unit.sv
test/sparse_polynomial_arith_unit_tb.sv
